### rtl/jdvf_pkg.sv
package jdvf_pkg;

  localparam int unsigned SampleW    = 10;
  localparam int unsigned VoteW      = 8;
  localparam int unsigned KeyW       = 4;
  localparam int unsigned RegionCnt  = 9;
  localparam int unsigned RegionW    = 4;

  // window bounds
  localparam logic [SampleW-1:0] LimLo    = 10'd200;
  localparam logic [SampleW-1:0] LimMidLo = 10'd400;
  localparam logic [SampleW-1:0] LimRtLo  = 10'd450;
  localparam logic [SampleW-1:0] LimMidHi = 10'd600;
  localparam logic [SampleW-1:0] LimHiLo  = 10'd800;
  localparam logic [SampleW-1:0] LimHiHi  = 10'd900;

  localparam logic [VoteW-1:0] VoteMax        = 8'hFF;
  localparam logic [VoteW-1:0] ThresholdReset = 8'd50;

  // key bit positions
  localparam int unsigned KeyLeft  = 0;
  localparam int unsigned KeyDown  = 1;
  localparam int unsigned KeyUp    = 2;
  localparam int unsigned KeyRight = 3;

  // counter index order
  typedef enum logic [RegionW-1:0] {
    REG_LEFT  = 4'd0,
    REG_DOWN  = 4'd1,
    REG_UP    = 4'd2,
    REG_RIGHT = 4'd3,
    REG_LD    = 4'd4,
    REG_LU    = 4'd5,
    REG_RU    = 4'd6,
    REG_RD    = 4'd7,
    REG_NONE  = 4'd8
  } region_t;

  typedef struct packed {
    logic [KeyW-1:0] keys;
    logic            decided;
  } vote_res_t;

  function automatic logic [KeyW-1:0] region_keys(input logic [RegionW-1:0] r);
    logic [KeyW-1:0] k;
    k = '0;
    unique case (r)
      REG_LEFT:  k[KeyLeft] = 1'b1;
      REG_DOWN:  k[KeyDown] = 1'b1;
      REG_UP:    k[KeyUp] = 1'b1;
      REG_RIGHT: k[KeyRight] = 1'b1;
      REG_LD: begin
        k[KeyLeft] = 1'b1;
        k[KeyDown] = 1'b1;
      end
      REG_LU: begin
        k[KeyLeft] = 1'b1;
        k[KeyUp] = 1'b1;
      end
      REG_RU: begin
        k[KeyUp] = 1'b1;
        k[KeyRight] = 1'b1;
      end
      REG_RD: begin
        k[KeyRight] = 1'b1;
        k[KeyDown] = 1'b1;
      end
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### rtl/jdvf_classify.sv
module jdvf_classify
  import jdvf_pkg::*;
(
  input  logic [SampleW-1:0] x_sample,
  input  logic [SampleW-1:0] y_sample,
  output region_t            region
);

  logic x_lo, x_up, x_rt, x_rd, x_dn;
  logic y_lo, y_left, y_right, y_rd, y_ld;

  assign x_lo    = x_sample < LimLo;
  assign x_up    = (x_sample > LimLo) && (x_sample < LimMidHi);
  assign x_rt    = x_sample > LimHiLo;
  assign x_rd    = x_sample > LimHiHi;
  assign x_dn    = (x_sample > LimRtLo) && (x_sample < LimMidHi);
  assign y_lo    = y_sample < LimLo;
  assign y_left  = (y_sample > LimMidLo) && (y_sample < LimMidHi);
  assign y_right = (y_sample > LimRtLo) && (y_sample < LimMidHi);
  assign y_rd    = y_sample > LimHiHi;
  assign y_ld    = y_sample > LimHiLo;

  // first matching window wins
  always_comb begin
    priority if (x_lo && y_left) region = REG_LEFT;
    else if (x_lo && y_lo)       region = REG_LU;
    else if (x_up && y_lo)       region = REG_UP;
    else if (x_rt && y_lo)       region = REG_RU;
    else if (x_rt && y_right)    region = REG_RIGHT;
    else if (x_rd && y_rd)       region = REG_RD;
    else if (x_dn && y_rd)       region = REG_DOWN;
    else if (x_lo && y_ld)       region = REG_LD;
    else                         region = REG_NONE;
  end

endmodule

### rtl/jdvf_vote.sv
module jdvf_vote
  import jdvf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  region_t          region,
  input  logic [VoteW-1:0] threshold,
  output vote_res_t        res
);

  logic [VoteW-1:0] votes_r   [RegionCnt];
  logic [VoteW-1:0] votes_inc [RegionCnt];
  logic [KeyW-1:0]  keys_r, keys_nxt;
  logic [RegionCnt-1:0] hit;
  logic [RegionW-1:0]   win;
  logic [VoteW-1:0]     thr;

  assign thr = (threshold == '0) ? VoteW'(1) : threshold;

  always_comb begin
    for (int i = 0; i < RegionCnt; i++) begin
      votes_inc[i] = votes_r[i];
      if ((RegionW'(i) == region) && (votes_r[i] != VoteMax)) begin
        votes_inc[i] = votes_r[i] + VoteW'(1);
      end
      hit[i] = votes_inc[i] >= thr;
    end
  end

  // lowest index among qualifying counters
  always_comb begin
    win = '0;
    for (int i = RegionCnt - 1; i >= 0; i--) begin
      if (hit[i]) win = RegionW'(i);
    end
  end

  assign keys_nxt    = (|hit) ? region_keys(win) : keys_r;
  assign res.keys    = keys_nxt;
  assign res.decided = |hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
      for (int i = 0; i < RegionCnt; i++) votes_r[i] <= '0;
    end else if (step) begin
      keys_r <= keys_nxt;
      for (int i = 0; i < RegionCnt; i++) begin
        votes_r[i] <= (|hit) ? '0 : votes_inc[i];
      end
    end
  end

endmodule

### rtl/joystick_direction_vote_filter.sv
// Joystick direction vote filter. Each request carries one 10-bit x,y
// sample; the block places it in one of nine regions (four directions, four
// diagonals, none) and bumps that region's vote counter. When any counter
// reaches cfg_vote_threshold (0 acts as 1) all counters clear and the four
// key outputs are rewritten; otherwise the keys hold. Exactly one result
// request per input request, in order. Throughput is one sample per clock
// while the result side does not stall; the only loop is the counter bank
// update. A sample passes the input register, then the result register, and
// is held in the input register while the result side stalls.
module joystick_direction_vote_filter
  import jdvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] in_x_sample,
  input  logic [SampleW-1:0] in_y_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_left_pressed,
  output logic               out_down_pressed,
  output logic               out_up_pressed,
  output logic               out_right_pressed,
  output logic               out_decided,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VoteW-1:0]   cfg_vote_threshold
);

  logic               s1_valid_r;
  logic [SampleW-1:0] s1_x_r, s1_y_r;
  logic               out_valid_r;
  vote_res_t          out_res_r;
  logic [VoteW-1:0]   thr_r;
  logic               advance;
  region_t            region;
  vote_res_t          res;

  // result register frees up when empty or being taken
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThresholdReset;
    end else if (cfg_valid) begin
      thr_r <= cfg_vote_threshold;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r <= in_x_sample;
      s1_y_r <= in_y_sample;
    end
  end

  jdvf_classify u_classify (
    .x_sample (s1_x_r),
    .y_sample (s1_y_r),
    .region   (region)
  );

  // counters and keys commit only when the sample moves to the result reg
  jdvf_vote u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .region    (region),
    .threshold (thr_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_left_pressed  = out_res_r.keys[KeyLeft];
  assign out_down_pressed  = out_res_r.keys[KeyDown];
  assign out_up_pressed    = out_res_r.keys[KeyUp];
  assign out_right_pressed = out_res_r.keys[KeyRight];
  assign out_decided       = out_res_r.decided;

endmodule
